/* sv/cbank_pkg.sv */
// shared types, codes and sizes for the counter bank with allocator
`default_nettype none

package cbank_pkg;

  localparam int MAX_COUNTERS = 256;
  localparam int ID_W         = $clog2(MAX_COUNTERS);
  localparam int CNT_W        = ID_W + 1;
  localparam int VAL_W        = 64;

  localparam logic [2:0] FN_CREATE  = 3'd0;
  localparam logic [2:0] FN_RELEASE = 3'd1;
  localparam logic [2:0] FN_READ    = 3'd2;
  localparam logic [2:0] FN_INC     = 3'd3;
  localparam logic [2:0] FN_DEC     = 3'd4;
  localparam logic [2:0] FN_RESTART = 3'd5;
  localparam logic [2:0] FN_SET     = 3'd6;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NEVER    = 2'd2;
  localparam logic [1:0] STAT_INACTIVE = 2'd3;

  typedef struct packed {
    logic [2:0]              func;
    logic [ID_W-1:0]         counter_id;
    logic signed [VAL_W-1:0] new_value;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [ID_W-1:0]         given_id;
    logic [1:0]              status;
  } out_res_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] gid;
    logic            zero_wr;
    logic [ID_W-1:0] zero_addr;
  } alloc_res_t;

endpackage

`default_nettype wire

/* sv/counter_bank_with_allocator_top.sv */
// counter bank top: request sequencer, counter value ram and update datapath
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_stall   cbank_pkg::in_req_t  (func, counter_id, new_value)
//   out_     out  out_valid / out_stall cbank_pkg::out_res_t (result_value, given_id, status)
//
// each request reads the value ram and free stack top when accepted in idle, then
// modifies and writes back in execute; no new request is taken until it writes back.
// the result waits in an output register; a stalled result holds back only the
// write-back cycle of the following request.
// synchronous reset clears active marks, stack depth and created count at once;
// the value ram and free stack need no clearing pass.
`default_nettype none

module counter_bank_with_allocator_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire cbank_pkg::in_req_t  in_req,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output cbank_pkg::out_res_t      out_res
);

  cbank_pkg::state_t     state_r, state_nxt;
  cbank_pkg::in_req_t    req_r;
  cbank_pkg::out_res_t   out_res_r, res_nxt;
  cbank_pkg::alloc_res_t alloc;
  logic                  out_valid_r;
  logic                  accept;
  logic                  fire;
  logic [cbank_pkg::VAL_W-1:0] val_q;
  logic signed [cbank_pkg::VAL_W-1:0] old_val;
  logic                  val_we;
  logic [cbank_pkg::ID_W-1:0]  val_wa;
  logic signed [cbank_pkg::VAL_W-1:0] val_wd;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbank_pkg::S_IDLE: if (in_valid) state_nxt = cbank_pkg::S_EXEC;
      cbank_pkg::S_EXEC: if (!out_valid_r || !out_stall) state_nxt = cbank_pkg::S_IDLE;
      default:           state_nxt = cbank_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    fire     = 1'b0;
    unique case (state_r)
      cbank_pkg::S_IDLE: in_stall = 1'b0;
      cbank_pkg::S_EXEC: fire = !out_valid_r || !out_stall;
      default: begin
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbank_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  cbank_alloc u_alloc (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .commit (fire),
    .req    (req_r),
    .res    (alloc)
  );

  cbank_ram #(
    .DATA_W (cbank_pkg::VAL_W),
    .DEPTH  (cbank_pkg::MAX_COUNTERS),
    .ADDR_W (cbank_pkg::ID_W)
  ) u_values (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_req.counter_id),
    .rd_data (val_q),
    .wr_en   (fire && val_we),
    .wr_addr (val_wa),
    .wr_data (val_wd)
  );

  assign old_val = val_q;

  always_comb begin
    res_nxt          = '0;
    res_nxt.status   = alloc.status;
    res_nxt.given_id = alloc.gid;
    val_we           = alloc.zero_wr;
    val_wa           = alloc.zero_addr;
    val_wd           = '0;
    if (alloc.status == cbank_pkg::STAT_OK) begin
      unique case (req_r.func)
        cbank_pkg::FN_READ: res_nxt.result_value = old_val;
        cbank_pkg::FN_INC: begin
          val_wd               = old_val + 64'sd1;
          val_we               = 1'b1;
          val_wa               = req_r.counter_id;
          res_nxt.result_value = val_wd;
        end
        cbank_pkg::FN_DEC: begin
          val_wd               = old_val - 64'sd1;
          val_we               = 1'b1;
          val_wa               = req_r.counter_id;
          res_nxt.result_value = val_wd;
        end
        cbank_pkg::FN_RESTART: begin
          val_we               = 1'b1;
          val_wa               = req_r.counter_id;
          res_nxt.result_value = old_val;
        end
        cbank_pkg::FN_SET: begin
          val_wd               = req_r.new_value;
          val_we               = 1'b1;
          val_wa               = req_r.counter_id;
          res_nxt.result_value = old_val;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == cbank_pkg::S_EXEC)
    else $error("accepted request did not move to execute");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("executed request produced no result");

  a_hold_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cbank_pkg::S_EXEC && out_valid_r && out_stall |=>
      state_r == cbank_pkg::S_EXEC)
    else $error("request left execute while result register was blocked");

endmodule

`default_nettype wire

/* sv/cbank_ram.sv */
// generic single-port-write, registered-read synchronous ram
`default_nettype none

module cbank_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/cbank_alloc.sv */
// id allocator: active marks, lifo free stack and never-used id count
`default_nettype none

module cbank_alloc (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 rd_en,
  input  wire logic                 commit,
  input  wire cbank_pkg::in_req_t   req,
  output cbank_pkg::alloc_res_t     res
);

  logic [cbank_pkg::MAX_COUNTERS-1:0] active_r, active_nxt;
  logic [cbank_pkg::CNT_W-1:0]        depth_r, depth_nxt;
  logic [cbank_pkg::CNT_W-1:0]        created_r, created_nxt;
  logic [cbank_pkg::CNT_W-1:0]        depth_dec;
  logic [cbank_pkg::ID_W-1:0]         stack_q;
  logic                               push;
  logic                               never;

  assign depth_dec = depth_r - cbank_pkg::CNT_W'(1);
  assign never     = {1'b0, req.counter_id} >= created_r;

  cbank_ram #(
    .DATA_W (cbank_pkg::ID_W),
    .DEPTH  (cbank_pkg::MAX_COUNTERS),
    .ADDR_W (cbank_pkg::ID_W)
  ) u_stack (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (depth_dec[cbank_pkg::ID_W-1:0]),
    .rd_data (stack_q),
    .wr_en   (commit && push),
    .wr_addr (depth_r[cbank_pkg::ID_W-1:0]),
    .wr_data (req.counter_id)
  );

  always_comb begin
    res         = '0;
    res.status  = cbank_pkg::STAT_OK;
    active_nxt  = active_r;
    depth_nxt   = depth_r;
    created_nxt = created_r;
    push        = 1'b0;
    unique case (req.func)
      cbank_pkg::FN_CREATE: begin
        if (depth_r != '0) begin
          res.gid             = stack_q;
          active_nxt[stack_q] = 1'b1;
          depth_nxt           = depth_dec;
        end else if (created_r < cbank_pkg::CNT_W'(cbank_pkg::MAX_COUNTERS)) begin
          res.gid        = created_r[cbank_pkg::ID_W-1:0];
          res.zero_wr    = 1'b1;
          res.zero_addr  = created_r[cbank_pkg::ID_W-1:0];
          active_nxt[created_r[cbank_pkg::ID_W-1:0]] = 1'b1;
          created_nxt    = created_r + cbank_pkg::CNT_W'(1);
        end else begin
          res.status = cbank_pkg::STAT_FULL;
        end
      end
      cbank_pkg::FN_RELEASE: begin
        if (never) begin
          res.status = cbank_pkg::STAT_NEVER;
        end else if (!active_r[req.counter_id]) begin
          res.status = cbank_pkg::STAT_INACTIVE;
        end else if (depth_r < cbank_pkg::CNT_W'(cbank_pkg::MAX_COUNTERS)) begin
          active_nxt[req.counter_id] = 1'b0;
          push                       = 1'b1;
          depth_nxt                  = depth_r + cbank_pkg::CNT_W'(1);
          res.zero_wr                = 1'b1;
          res.zero_addr              = req.counter_id;
        end
      end
      cbank_pkg::FN_READ, cbank_pkg::FN_INC, cbank_pkg::FN_DEC,
      cbank_pkg::FN_RESTART, cbank_pkg::FN_SET: begin
        if (never) begin
          res.status = cbank_pkg::STAT_NEVER;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      depth_r   <= '0;
      created_r <= '0;
    end else if (commit) begin
      active_r  <= active_nxt;
      depth_r   <= depth_nxt;
      created_r <= created_nxt;
    end
  end

  // every created id is either active or waiting on the free stack
  a_id_balance: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(active_r) + int'(depth_r) == int'(created_r))
    else $error("active ids plus free stack depth differ from created count");

  a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
    created_r <= cbank_pkg::CNT_W'(cbank_pkg::MAX_COUNTERS))
    else $error("created count beyond pool size");

endmodule

`default_nettype wire
